@@ rtl/m3inv_pkg.sv @@
package m3inv_pkg;

  // Element format: signed Q(EW-FB).FB
  localparam int EW   = 32;
  localparam int FB   = 16;
  localparam int NE   = 9;

  // Derived widths
  localparam int PW   = 2 * EW;          // 2x2 product
  localparam int CW   = PW + 1;          // cofactor, signed
  localparam int PRW  = EW + CW;         // element times cofactor
  localparam int DETW = PRW + 2;         // determinant, signed
  localparam int NUMW = CW + 2 * FB;     // scaled cofactor magnitude
  localparam int CMPW = DETW + EW;       // divider compare width
  localparam int QW   = EW + 1;          // rounded quotient
  localparam int IW   = 4;               // element index

  // Divider depth: overflow check, one stage per quotient bit, round/clip
  localparam int NS   = EW + 2;

  typedef logic signed [EW-1:0]   elem_t;
  typedef logic signed [CW-1:0]   cof_t;
  typedef logic [CW-1:0]          cmag_t;
  typedef logic [DETW-1:0]        dmag_t;
  typedef logic [NUMW-1:0]        num_t;
  typedef logic [CMPW-1:0]        wide_t;
  typedef logic [IW-1:0]          idx_t;

  // Adjugate in row order: cof[k] = a[x]*a[y] - a[u]*a[v], entries {x, y, u, v}
  localparam idx_t COF_IDX [NE][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // Determinant uses the first column of the adjugate
  localparam idx_t DET_COF [3] = '{4'd0, 4'd3, 4'd6};

  localparam elem_t ELEM_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam elem_t ELEM_MIN = {1'b1, {(EW-1){1'b0}}};

endpackage

@@ rtl/matrix3x3_inverse_core.sv @@
// 3x3 matrix inverse by the adjugate, signed Q16.16 in and out. Fully
// pipelined: one matrix per cycle in and out while the output is not
// stalled, through the cofactor products, the determinant and the nine parallel
// restoring dividers that resolve one quotient bit per stage. Results are
// rounded half away from zero and clipped to the element range; a zero
// determinant gives all-zero elements with singular set. Backpressure on
// the output stalls only as far back as needed to fill pipeline bubbles.
module matrix3x3_inverse_core import m3inv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  elem_t a11,
  input  elem_t a12,
  input  elem_t a13,
  input  elem_t a21,
  input  elem_t a22,
  input  elem_t a23,
  input  elem_t a31,
  input  elem_t a32,
  input  elem_t a33,
  output logic  out_valid,
  input  logic  out_ready,
  output elem_t r11,
  output elem_t r12,
  output elem_t r13,
  output elem_t r21,
  output elem_t r22,
  output elem_t r23,
  output elem_t r31,
  output elem_t r32,
  output elem_t r33,
  output logic  singular,
  output logic  saturated
);

  elem_t a [NE];
  elem_t r [NE];
  cof_t  cof [NE];
  elem_t row1 [3];
  cmag_t cmag [NE];
  logic  ng [NE];
  dmag_t dmag;
  logic  dzero;
  logic  cof_valid, cof_ready;
  logic  det_valid, det_ready;

  assign a = '{a11, a12, a13, a21, a22, a23, a31, a32, a33};

  m3inv_cof u_cof (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .a         (a),
    .out_valid (cof_valid),
    .out_ready (cof_ready),
    .cof       (cof),
    .row1      (row1)
  );

  m3inv_det u_det (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cof_valid),
    .in_ready  (cof_ready),
    .cof       (cof),
    .row1      (row1),
    .out_valid (det_valid),
    .out_ready (det_ready),
    .cmag      (cmag),
    .ng        (ng),
    .dmag      (dmag),
    .dzero     (dzero)
  );

  m3inv_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (det_valid),
    .in_ready  (det_ready),
    .cmag      (cmag),
    .ng        (ng),
    .dmag      (dmag),
    .dzero     (dzero),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .r         (r),
    .singular  (singular),
    .saturated (saturated)
  );

  assign r11 = r[0];
  assign r12 = r[1];
  assign r13 = r[2];
  assign r21 = r[3];
  assign r22 = r[4];
  assign r23 = r[5];
  assign r31 = r[6];
  assign r32 = r[7];
  assign r33 = r[8];

`ifndef SYNTH
  // Pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Singular result carries zero elements and no clip flag
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && singular) |->
      (r11 == '0 && r12 == '0 && r13 == '0 && r21 == '0 && r22 == '0 &&
       r23 == '0 && r31 == '0 && r32 == '0 && r33 == '0 && !saturated))
    else $error("singular result with nonzero data");

  // A clip flag means some element sits at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (r11 == ELEM_MAX || r11 == ELEM_MIN || r12 == ELEM_MAX || r12 == ELEM_MIN ||
       r13 == ELEM_MAX || r13 == ELEM_MIN || r21 == ELEM_MAX || r21 == ELEM_MIN ||
       r22 == ELEM_MAX || r22 == ELEM_MIN || r23 == ELEM_MAX || r23 == ELEM_MIN ||
       r31 == ELEM_MAX || r31 == ELEM_MIN || r32 == ELEM_MAX || r32 == ELEM_MIN ||
       r33 == ELEM_MAX || r33 == ELEM_MIN))
    else $error("saturated without a clipped element");
`endif

endmodule

@@ rtl/m3inv_cof.sv @@
module m3inv_cof import m3inv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  elem_t a [NE],
  output logic  out_valid,
  input  logic  out_ready,
  output cof_t  cof [NE],
  output elem_t row1 [3]
);

  logic                 v1, v2;
  logic                 en1, en2;
  logic signed [PW-1:0] prod [2*NE];
  elem_t                row1_s1 [3];

  // Stage enables: a stage loads when empty or when its successor moves
  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  // Stage 1: eighteen 2x2 products
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int k = 0; k < NE; k++) begin
        prod[2*k]   <= a[COF_IDX[k][0]] * a[COF_IDX[k][1]];
        prod[2*k+1] <= a[COF_IDX[k][2]] * a[COF_IDX[k][3]];
      end
      for (int j = 0; j < 3; j++) row1_s1[j] <= a[j];
    end
  end

  // Stage 2: cofactor differences
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int k = 0; k < NE; k++) cof[k] <= CW'(prod[2*k]) - CW'(prod[2*k+1]);
      row1 <= row1_s1;
    end
  end

endmodule

@@ rtl/m3inv_det.sv @@
module m3inv_det import m3inv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  cof_t  cof [NE],
  input  elem_t row1 [3],
  output logic  out_valid,
  input  logic  out_ready,
  output cmag_t cmag [NE],
  output logic  ng [NE],
  output dmag_t dmag,
  output logic  dzero
);

  logic                   v [4];
  logic                   en [4];
  logic signed [2*EW:0]   plo [3];
  logic signed [2*EW:0]   phi [3];
  logic signed [PRW-1:0]  term [3];
  logic signed [DETW-1:0] det;
  cmag_t                  cmag_s [3][NE];
  logic                   cneg_s [3][NE];

  // Stage enables, last one from downstream
  assign en[3] = !v[3] || out_ready;
  assign en[2] = !v[2] || en[3];
  assign en[1] = !v[1] || en[2];
  assign en[0] = !v[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 4; s++) v[s] <= 1'b0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int s = 1; s < 4; s++) if (en[s]) v[s] <= v[s-1];
    end
  end

  // Stage 1: split each determinant cofactor into a low and a high half and multiply
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int j = 0; j < 3; j++) begin
        plo[j] <= row1[j] * $signed({1'b0, cof[DET_COF[j]][EW-1:0]});
        phi[j] <= row1[j] * $signed(cof[DET_COF[j]][CW-1:EW]);
      end
      for (int k = 0; k < NE; k++) begin
        cneg_s[0][k] <= cof[k][CW-1];
        cmag_s[0][k] <= cof[k][CW-1] ? cmag_t'(-cof[k]) : cmag_t'(cof[k]);
      end
    end
  end

  // Stage 2: recombine partial products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int j = 0; j < 3; j++)
        term[j] <= (PRW'(phi[j]) <<< EW) + PRW'(plo[j]);
      cmag_s[1] <= cmag_s[0];
      cneg_s[1] <= cneg_s[0];
    end
  end

  // Stage 3: determinant sum
  always_ff @(posedge clk) begin
    if (en[2]) begin
      det <= DETW'(term[0]) + DETW'(term[1]) + DETW'(term[2]);
      cmag_s[2] <= cmag_s[1];
      cneg_s[2] <= cneg_s[1];
    end
  end

  // Stage 4: determinant magnitude, quotient signs
  always_ff @(posedge clk) begin
    if (en[3]) begin
      dmag  <= det[DETW-1] ? dmag_t'(-det) : dmag_t'(det);
      dzero <= (det == '0);
      for (int k = 0; k < NE; k++) ng[k] <= cneg_s[2][k] ^ det[DETW-1];
      cmag <= cmag_s[2];
    end
  end

endmodule

@@ rtl/m3inv_div.sv @@
module m3inv_div import m3inv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  cmag_t cmag [NE],
  input  logic  ng [NE],
  input  dmag_t dmag,
  input  logic  dzero,
  output logic  out_valid,
  input  logic  out_ready,
  output elem_t r [NE],
  output logic  singular,
  output logic  saturated
);

  // Stage 0 checks overflow, stages 1..EW each resolve one quotient bit,
  // stage EW+1 rounds and saturates.

  logic          v [NS];
  logic          en [NS];
  num_t          rem_s [NS-1][NE];
  logic [EW-1:0] q_s [NS-1][NE];
  logic          ovf_s [NS-1][NE];
  logic          ng_s [NS-1][NE];
  dmag_t         dmag_s [NS-1];
  logic          dzero_s [NS-1];

  assign en[NS-1] = !v[NS-1] || out_ready;
  for (genvar s = 0; s < NS - 1; s++) begin : g_en
    assign en[s] = !v[s] || en[s+1];
  end
  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NS; s++) v[s] <= 1'b0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int s = 1; s < NS; s++) if (en[s]) v[s] <= v[s-1];
    end
  end

  // Stage 0: quotient of 2^EW or more always saturates
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < NE; k++) begin
        rem_s[0][k] <= {cmag[k], {(2*FB){1'b0}}};
        q_s[0][k]   <= '0;
        ovf_s[0][k] <= (wide_t'(cmag[k]) << (2*FB)) >= (wide_t'(dmag) << EW);
        ng_s[0][k]  <= ng[k];
      end
      dmag_s[0]  <= dmag;
      dzero_s[0] <= dzero;
    end
  end

  // Restoring division steps, most significant quotient bit first
  for (genvar j = 1; j < NS - 1; j++) begin : g_step
    logic  ge [NE];
    wide_t dsh;

    always_comb begin
      dsh = wide_t'(dmag_s[j-1]) << (EW - j);
      for (int k = 0; k < NE; k++) ge[k] = wide_t'(rem_s[j-1][k]) >= dsh;
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        for (int k = 0; k < NE; k++) begin
          rem_s[j][k] <= ge[k] ? NUMW'(wide_t'(rem_s[j-1][k]) - dsh) : rem_s[j-1][k];
          q_s[j][k]   <= {q_s[j-1][k][EW-2:0], ge[k]};
          ovf_s[j][k] <= ovf_s[j-1][k];
          ng_s[j][k]  <= ng_s[j-1][k];
        end
        dmag_s[j]  <= dmag_s[j-1];
        dzero_s[j] <= dzero_s[j-1];
      end
    end
  end

  // Output stage: round half away from zero, apply sign, clip
  logic [QW-1:0] qr [NE];
  logic          clip [NE];
  elem_t         val [NE];
  logic          any_clip;

  always_comb begin
    any_clip = 1'b0;
    for (int k = 0; k < NE; k++) begin
      qr[k] = QW'(q_s[NS-2][k])
            + QW'((wide_t'(rem_s[NS-2][k]) << 1) >= wide_t'(dmag_s[NS-2]));
      if (ng_s[NS-2][k])
        clip[k] = ovf_s[NS-2][k] || (qr[k] > (QW'(1) << (EW - 1)));
      else
        clip[k] = ovf_s[NS-2][k] || (qr[k] >= (QW'(1) << (EW - 1)));
      if (clip[k])
        val[k] = ng_s[NS-2][k] ? ELEM_MIN : ELEM_MAX;
      else
        val[k] = ng_s[NS-2][k] ? elem_t'(-qr[k][EW-1:0]) : elem_t'(qr[k][EW-1:0]);
      any_clip = any_clip | clip[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      for (int k = 0; k < NE; k++) r[k] <= dzero_s[NS-2] ? '0 : val[k];
      singular  <= dzero_s[NS-2];
      saturated <= !dzero_s[NS-2] && any_clip;
    end
  end

endmodule
